// ===== src/rfsb_pkg.sv =====
// Shared constants and codes for the rectangle fill and sprite blitter.
// Used by the blitter top level, the checker and the testbench; no dependencies.
package rfsb_pkg;

  localparam int DefMaxFrameW = 256;
  localparam int DefMaxFrameH = 256;

  // Bit position of the alpha byte inside an ARGB pixel.
  localparam int AlphaShift = 24;

  // Wide enough for signed coordinates, rectangle ends and frame sizes up to 4096.
  localparam int CoordW = 14;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam int PixelW = 32;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpFillRect = 2'd1;
  localparam logic [1:0] OpImagePixel = 2'd2;
  localparam logic [1:0] OpReadPixel = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBackgroundColor = 2'd2;

endpackage

// ===== src/rect_fill_sprite_blitter_unit.sv =====
// Rectangle fill and sprite blitter over a 32-bit ARGB frame store.
// Depends on rfsb_pkg and on the rfsb_ram frame store memory.
//
// Every command runs alone: it is taken, clipped against the frame, and then carried out on
// the single-ported frame store RAM. An image pixel that lands is written as a one-pixel
// rectangle; one that is dropped returns to idle. A fill or clear writes each pixel of the
// clipped rectangle row by row (a clear of a W x H frame writes W*H pixels). A read issues
// the RAM read, skipped when the point lies outside the frame, and its last state loads the
// output register from the registered RAM read, or with zero for a point outside the frame.
// A finished read may wait in the output register while the next command is taken; a second
// read holds until that register is free. The frame store is not cleared after reset, so a
// clear command must come before the first read.
module rect_fill_sprite_blitter_unit
  import rfsb_pkg::*;
#(
  parameter int MaxFrameW = DefMaxFrameW,
  parameter int MaxFrameH = DefMaxFrameH
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic signed [10:0]  origin_x_i,
  input  logic signed [10:0]  origin_y_i,
  input  logic [9:0]          extent_w_i,
  input  logic [9:0]          extent_h_i,
  input  logic [7:0]          offset_x_i,
  input  logic [7:0]          offset_y_i,
  input  logic [31:0]         color_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixelW-1:0]   pixel_data_o
);

  localparam int ColW = $clog2(MaxFrameW);
  localparam int RowW = $clog2(MaxFrameH);
  localparam int Depth = MaxFrameW * MaxFrameH;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [2:0] {
    StIdle,
    StCalc,
    StWalk,
    StRdIssue,
    StRdWait
  } state_e;

  // Configuration registers.
  logic [8:0]        frame_width_q;
  logic [8:0]        frame_height_q;
  logic [PixelW-1:0] background_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q      <= 9'd256;
      frame_height_q     <= 9'd256;
      background_color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:      frame_width_q      <= cfg_wdata_i[8:0];
        CfgFrameHeight:     frame_height_q     <= cfg_wdata_i[8:0];
        CfgBackgroundColor: background_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e            state_q;
  logic              out_valid_q;
  logic [PixelW-1:0] pixel_q;
  logic              rd_zero_q;

  // Latched transaction fields.
  logic [1:0]         op_q;
  logic signed [10:0] ox_q;
  logic signed [10:0] oy_q;
  logic [9:0]         ew_q;
  logic [9:0]         eh_q;
  logic [7:0]         dx_q;
  logic [7:0]         dy_q;
  logic [PixelW-1:0]  color_q;

  // Walker position and clipped bounds.
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] x_first_q;
  logic [ColW-1:0] x_last_q;
  logic [RowW-1:0] y_last_q;

  logic in_accept;
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Effective frame size, clamped to the store dimensions.
  logic signed [CoordW-1:0] eff_w;
  logic signed [CoordW-1:0] eff_h;
  always_comb begin
    eff_w = $signed({{(CoordW-9){1'b0}}, frame_width_q});
    eff_h = $signed({{(CoordW-9){1'b0}}, frame_height_q});
    if (eff_w > $signed(CoordW'(MaxFrameW))) begin
      eff_w = $signed(CoordW'(MaxFrameW));
    end
    if (eff_h > $signed(CoordW'(MaxFrameH))) begin
      eff_h = $signed(CoordW'(MaxFrameH));
    end
  end

  // Every command reduces to a half-open rectangle that is clipped against the frame.
  // An image pixel or a read is a one-pixel rectangle at its target point.
  logic signed [CoordW-1:0] ox_s, oy_s, ew_s, eh_s, dx_s, dy_s;
  logic signed [CoordW-1:0] rx0, ry0, rx1, ry1;
  logic signed [CoordW-1:0] cx0, cy0, cx1, cy1;
  logic                     extra_ok;
  logic                     clip_ok;
  logic signed [CoordW-1:0] cx_last, cy_last;

  always_comb begin
    ox_s = CoordW'(ox_q);
    oy_s = CoordW'(oy_q);
    ew_s = $signed({{(CoordW-10){1'b0}}, ew_q});
    eh_s = $signed({{(CoordW-10){1'b0}}, eh_q});
    dx_s = $signed({{(CoordW-8){1'b0}}, dx_q});
    dy_s = $signed({{(CoordW-8){1'b0}}, dy_q});
    extra_ok = 1'b1;
    unique case (op_q)
      OpClear: begin
        rx0 = '0;
        ry0 = '0;
        rx1 = eff_w;
        ry1 = eff_h;
      end
      OpFillRect: begin
        rx0 = ox_s;
        ry0 = oy_s;
        rx1 = ox_s + ew_s;
        ry1 = oy_s + eh_s;
      end
      OpImagePixel: begin
        rx0 = ox_s + dx_s;
        ry0 = oy_s + dy_s;
        rx1 = rx0 + CoordW'(1);
        ry1 = ry0 + CoordW'(1);
        // Offsets must lie inside the sprite limits; zero alpha is transparent.
        extra_ok = ({2'b00, dx_q} < ew_q) && ({2'b00, dy_q} < eh_q)
                   && (color_q[AlphaShift +: 8] != 8'd0);
      end
      default: begin
        rx0 = ox_s;
        ry0 = oy_s;
        rx1 = ox_s + CoordW'(1);
        ry1 = oy_s + CoordW'(1);
      end
    endcase
    cx0 = (rx0 < 0) ? '0 : rx0;
    cy0 = (ry0 < 0) ? '0 : ry0;
    cx1 = (rx1 > eff_w) ? eff_w : rx1;
    cy1 = (ry1 > eff_h) ? eff_h : ry1;
    clip_ok = (cx0 < cx1) && (cy0 < cy1) && extra_ok;
    cx_last = cx1 - CoordW'(1);
    cy_last = cy1 - CoordW'(1);
  end

  // Frame store: fixed stride of MaxFrameW words per row.
  logic [AddrW-1:0]  mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [PixelW-1:0] mem_rdata;

  assign mem_addr = AddrW'(row_q) * AddrW'(MaxFrameW) + AddrW'(col_q);
  assign mem_we   = (state_q == StWalk);
  assign mem_re   = (state_q == StRdIssue);

  rfsb_ram #(
    .Width(PixelW),
    .Depth(Depth)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_addr),
    .wdata_i(color_q),
    .re_i   (mem_re),
    .raddr_i(mem_addr),
    .rdata_o(mem_rdata)
  );

  logic walk_end;
  assign walk_end = (col_q == x_last_q) && (row_q == y_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      pixel_q     <= '0;
    end else begin
      // While a read finishes, the output register is handled in its own state below.
      if (out_valid_q && !out_stall_i && (state_q != StRdWait)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_accept) begin
            state_q <= StCalc;
          end
        end
        StCalc: begin
          if (op_q == OpReadPixel) begin
            state_q <= clip_ok ? StRdIssue : StRdWait;
          end else begin
            state_q <= clip_ok ? StWalk : StIdle;
          end
        end
        StWalk: begin
          if (walk_end) begin
            state_q <= StIdle;
          end
        end
        StRdIssue: begin
          state_q <= StRdWait;
        end
        StRdWait: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            pixel_q     <= rd_zero_q ? '0 : mem_rdata;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= operation_i;
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      ew_q    <= extent_w_i;
      eh_q    <= extent_h_i;
      dx_q    <= offset_x_i;
      dy_q    <= offset_y_i;
      color_q <= color_i;
    end
    if (state_q == StCalc) begin
      if (op_q == OpClear) begin
        color_q <= background_color_q;
      end
      rd_zero_q <= !clip_ok;
      col_q     <= cx0[ColW-1:0];
      row_q     <= cy0[RowW-1:0];
      x_first_q <= cx0[ColW-1:0];
      x_last_q  <= cx_last[ColW-1:0];
      y_last_q  <= cy_last[RowW-1:0];
    end
    if (state_q == StWalk) begin
      if (col_q == x_last_q) begin
        col_q <= x_first_q;
        row_q <= row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_data_o = pixel_q;

`ifndef NO_ASSERTIONS
  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (col_q <= x_last_q) && (row_q <= y_last_q) &&
                            (col_q >= x_first_q))
    else $error("frame walker left its rectangle");

  a_walk_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk || state_q == StRdIssue) |->
      ($signed({{(CoordW-ColW){1'b0}}, col_q}) < eff_w) &&
      ($signed({{(CoordW-RowW){1'b0}}, row_q}) < eff_h))
    else $error("frame store accessed outside the active frame");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StRdWait) && $past(op_q == OpReadPixel))
    else $error("result produced without a read transaction");
`endif

endmodule

// ===== src/rfsb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the frame store of the blitter.
module rfsb_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/rfsb_checker.sv =====
// Scoreboard for the rectangle fill and sprite blitter: keeps a shadow frame store and
// configuration, predicts read-back pixels and compares them with the output channel.
// Depends on rfsb_pkg for field widths, command codes and register indexes.
module rfsb_checker
  import rfsb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          operation_i,
  input  logic signed [10:0]  origin_x_i,
  input  logic signed [10:0]  origin_y_i,
  input  logic [9:0]          extent_w_i,
  input  logic [9:0]          extent_h_i,
  input  logic [7:0]          offset_x_i,
  input  logic [7:0]          offset_y_i,
  input  logic [31:0]         color_i,

  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [PixelW-1:0]   pixel_data_i,

  output int                  outstanding_o,
  output int                  error_count_o
);

  localparam int StoreWords = DefMaxFrameW * DefMaxFrameH;

  logic [PixelW-1:0] frame_mem [StoreWords];
  logic [PixelW-1:0] expected_pixels_q [$];
  logic [PixelW-1:0] clear_color;
  logic [PixelW-1:0] want_pixel;
  int frame_w_eff;
  int frame_h_eff;
  int mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: pixel check: %s", $time, msg);
    mismatches++;
  endtask

  // Fills [x0,x1) x [y0,y1) after clipping it to the active frame.
  task automatic paint_rect(input int x0, input int y0, input int x1, input int y1,
                            input logic [PixelW-1:0] c);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > frame_w_eff) x1 = frame_w_eff;
    if (y1 > frame_h_eff) y1 = frame_h_eff;
    for (int y = y0; y < y1; y++)
      for (int x = x0; x < x1; x++)
        frame_mem[y * DefMaxFrameW + x] = c;
  endtask

  task automatic predict_command(input logic [1:0] op, input int ox, input int oy,
                                 input int ew, input int eh, input int dx, input int dy,
                                 input logic [PixelW-1:0] c);
    int tx;
    int ty;
    tx = ox + dx;
    ty = oy + dy;
    case (op)
      OpClear: paint_rect(0, 0, frame_w_eff, frame_h_eff, clear_color);
      OpFillRect: paint_rect(ox, oy, ox + ew, oy + eh, c);
      OpImagePixel: begin
        // A sprite pixel lands only inside the sprite limits, inside the frame and when opaque.
        if (dx < ew && dy < eh && tx >= 0 && ty >= 0 && tx < frame_w_eff &&
            ty < frame_h_eff && c[PixelW-1:AlphaShift] != '0)
          frame_mem[ty * DefMaxFrameW + tx] = c;
      end
      OpReadPixel: begin
        if (ox >= 0 && oy >= 0 && ox < frame_w_eff && oy < frame_h_eff)
          expected_pixels_q.push_back(frame_mem[oy * DefMaxFrameW + ox]);
        else
          expected_pixels_q.push_back('0);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_eff = DefMaxFrameW;
      frame_h_eff = DefMaxFrameH;
      clear_color = '0;
      expected_pixels_q.delete();
      outstanding_o <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgFrameWidth: frame_w_eff = (cfg_wdata_i[8:0] > DefMaxFrameW) ? DefMaxFrameW
                                                                         : int'(cfg_wdata_i[8:0]);
          CfgFrameHeight: frame_h_eff = (cfg_wdata_i[8:0] > DefMaxFrameH) ? DefMaxFrameH
                                                                          : int'(cfg_wdata_i[8:0]);
          CfgBackgroundColor: clear_color = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels_q.size() == 0) begin
          report_mismatch($sformatf("pixel %h returned with no read outstanding", pixel_data_i));
        end else begin
          want_pixel = expected_pixels_q.pop_front();
          if (pixel_data_i !== want_pixel)
            report_mismatch($sformatf("pixel_data %h, expected %h", pixel_data_i, want_pixel));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_command(operation_i, origin_x_i, origin_y_i, extent_w_i, extent_h_i,
                        offset_x_i, offset_y_i, color_i);
      outstanding_o <= expected_pixels_q.size();
      error_count_o <= mismatches;
    end
  end

endmodule

// ===== dv/tb_rect_fill_sprite_blitter_unit.sv =====
// Top of the blitter testbench: clock, reset, configuration, command stimulus, output
// back-pressure and the final verdict. Depends on rfsb_pkg, rfsb_checker and the blitter RTL.
module tb_rect_fill_sprite_blitter_unit;
  import rfsb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareIndex = 2'd3;
  localparam int PhaseCount = 8;
  localparam int ItemsPerPhase = 155;
  localparam int SettleCycles = 8;
  localparam int HoldAfterReads = 30;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] ox;
    logic [10:0] oy;
    logic [9:0]  ew;
    logic [9:0]  eh;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [31:0] color;
  } blit_cmd_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          operation_i = OpClear;
  logic signed [10:0]  origin_x_i = '0;
  logic signed [10:0]  origin_y_i = '0;
  logic [9:0]          extent_w_i = '0;
  logic [9:0]          extent_h_i = '0;
  logic [7:0]          offset_x_i = '0;
  logic [7:0]          offset_y_i = '0;
  logic [31:0]         color_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixelW-1:0]   pixel_data_o;

  int pixels_pending;
  int error_count;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int frame_w_eff = DefMaxFrameW;
  int frame_h_eff = DefMaxFrameH;
  int reads_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  int phase_w [PhaseCount] = '{16, 511, 0, 256, 1, 100, 37, 200};
  int phase_h [PhaseCount] = '{16, 7, 40, 256, 1, 511, 0, 3};

  rect_fill_sprite_blitter_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .origin_x_i,
    .origin_y_i,
    .extent_w_i,
    .extent_h_i,
    .offset_x_i,
    .offset_y_i,
    .color_i,
    .out_valid_o,
    .out_stall_i,
    .pixel_data_o
  );

  rfsb_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .operation_i,
    .origin_x_i,
    .origin_y_i,
    .extent_w_i,
    .extent_h_i,
    .offset_x_i,
    .offset_y_i,
    .color_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .pixel_data_i  (pixel_data_o),
    .outstanding_o (pixels_pending),
    .error_count_o (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Output back-pressure, with one long hold-off that backs the block up into its input.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) reads_seen <= reads_seen + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && reads_seen == HoldAfterReads) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic blit_cmd_t cmd_of(input logic [1:0] op, input int ox, input int oy,
                                       input int ew, input int eh, input int dx, input int dy,
                                       input logic [31:0] color);
    blit_cmd_t cmd;
    cmd.op = op;
    cmd.ox = 11'(ox);
    cmd.oy = 11'(oy);
    cmd.ew = 10'(ew);
    cmd.eh = 10'(eh);
    cmd.dx = 8'(dx);
    cmd.dy = 8'(dy);
    cmd.color = color;
    return cmd;
  endfunction

  // A coordinate anywhere from -4 up to a frame dimension plus 3.
  function automatic int near_coord(input int size);
    return int'($urandom_range(size + 7)) - 4;
  endfunction

  function automatic blit_cmd_t make_cmd();
    blit_cmd_t cmd;
    int pick;
    int sx;
    int sy;
    int x0;
    int y0;
    int x1;
    int y1;
    bit noisy;
    cmd = cmd_of(OpReadPixel, $urandom_range(2047), $urandom_range(2047), $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(255), $urandom_range(255), $urandom());
    noisy = ($urandom_range(99) < 15);
    pick = $urandom_range(99);
    if (pick < 3 && frame_w_eff * frame_h_eff <= 4096) cmd.op = OpClear;
    else if (pick < 25) cmd.op = OpFillRect;
    else if (pick < 65) cmd.op = OpImagePixel;
    else cmd.op = OpReadPixel;
    case (cmd.op)
      OpFillRect: begin
        if (noisy) begin
          // Wide random rectangles are kept only when their clipped area stays modest.
          do begin
            cmd.ox = 11'($urandom_range(2047));
            cmd.oy = 11'($urandom_range(2047));
            cmd.ew = 10'($urandom_range(1023));
            cmd.eh = 10'($urandom_range(1023));
            sx = int'($signed(cmd.ox));
            sy = int'($signed(cmd.oy));
            x0 = (sx < 0) ? 0 : sx;
            y0 = (sy < 0) ? 0 : sy;
            x1 = sx + int'(cmd.ew);
            y1 = sy + int'(cmd.eh);
            if (x1 > frame_w_eff) x1 = frame_w_eff;
            if (y1 > frame_h_eff) y1 = frame_h_eff;
          end while (x1 > x0 && y1 > y0 && (x1 - x0) * (y1 - y0) > 2048);
        end else begin
          cmd.ox = 11'(near_coord(frame_w_eff));
          cmd.oy = 11'(near_coord(frame_h_eff));
          cmd.ew = 10'($urandom_range(12));
          cmd.eh = 10'($urandom_range(12));
        end
      end
      OpImagePixel: begin
        if (!noisy) begin
          cmd.ew = 10'($urandom_range(1, 64));
          cmd.eh = 10'($urandom_range(1, 64));
          cmd.dx = 8'($urandom_range(int'(cmd.ew)));
          cmd.dy = 8'($urandom_range(int'(cmd.eh)));
          cmd.ox = 11'(near_coord(frame_w_eff) - int'(cmd.dx));
          cmd.oy = 11'(near_coord(frame_h_eff) - int'(cmd.dy));
          if ($urandom_range(9) == 0) cmd.color[PixelW-1:AlphaShift] = '0;
        end
      end
      OpReadPixel: begin
        if (!noisy) begin
          if (frame_w_eff > 0 && frame_h_eff > 0 && $urandom_range(9) != 0) begin
            cmd.ox = 11'($urandom_range(frame_w_eff - 1));
            cmd.oy = 11'($urandom_range(frame_h_eff - 1));
          end else begin
            cmd.ox = 11'(near_coord(frame_w_eff));
            cmd.oy = 11'(near_coord(frame_h_eff));
          end
        end
      end
      default: ;
    endcase
    return cmd;
  endfunction

  task automatic send_cmd(input blit_cmd_t cmd);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= cmd.op;
    origin_x_i <= cmd.ox;
    origin_y_i <= cmd.oy;
    extent_w_i <= cmd.ew;
    extent_h_i <= cmd.eh;
    offset_x_i <= cmd.dx;
    offset_y_i <= cmd.dy;
    color_i <= cmd.color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Upper data bits are random so that the 9-bit size registers must ignore them.
  task automatic program_frame(input logic [8:0] w, input logic [8:0] h, input logic [31:0] bg);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgFrameWidth;
    cfg_wdata_i <= {23'($urandom()), w};
    @(posedge clk_i);
    cfg_index_i <= CfgFrameHeight;
    cfg_wdata_i <= {23'($urandom()), h};
    @(posedge clk_i);
    cfg_index_i <= CfgBackgroundColor;
    cfg_wdata_i <= bg;
    @(posedge clk_i);
    cfg_index_i <= CfgSpareIndex;
    cfg_wdata_i <= $urandom();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frame_w_eff = (w > DefMaxFrameW) ? DefMaxFrameW : int'(w);
    frame_h_eff = (h > DefMaxFrameH) ? DefMaxFrameH : int'(h);
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    // Full-size clear first, so every pixel of the store is defined before any read.
    program_frame(9'd256, 9'd256, $urandom());
    send_cmd(cmd_of(OpClear, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 255, 255, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, -1024, -1024, 1023, 1023, 255, 255, 32'hFFFF_FFFF));
    send_cmd(cmd_of(OpReadPixel, 1023, 1023, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 256, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpFillRect, -1024, -1024, 1023, 1023, 0, 0, 32'hFFFF_FFFF));
    send_cmd(cmd_of(OpFillRect, 250, 250, 1023, 1023, 0, 0, 32'hFFFF_FFFF));
    send_cmd(cmd_of(OpFillRect, 0, 0, 0, 5, 0, 0, 32'h1234_5678));
    send_cmd(cmd_of(OpFillRect, 0, 0, 5, 0, 0, 0, 32'h1234_5678));
    send_cmd(cmd_of(OpImagePixel, 0, 0, 1023, 1023, 255, 255, 32'h0100_0000));
    send_cmd(cmd_of(OpImagePixel, 10, 10, 4, 4, 0, 0, 32'h00FF_FFFF));
    send_cmd(cmd_of(OpImagePixel, 20, 20, 5, 5, 5, 0, 32'hFF00_FF00));
    send_cmd(cmd_of(OpImagePixel, 20, 20, 5, 5, 0, 5, 32'hFF00_FF00));
    send_cmd(cmd_of(OpImagePixel, 1023, 1023, 1023, 1023, 0, 0, 32'hFFFF_FFFF));
    send_cmd(cmd_of(OpImagePixel, -1024, -1024, 1023, 1023, 255, 255, 32'hFFFF_FFFF));
    send_cmd(cmd_of(OpImagePixel, 3, 4, 3, 2, 2, 1, 32'h80AB_CDEF));
    send_cmd(cmd_of(OpReadPixel, 255, 255, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 10, 10, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 25, 20, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 250, 250, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 5, 5, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OpReadPixel, 0, 0, 0, 0, 0, 0, 0));
    in_valid_i <= 1'b0;
    drain_results();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 3) begin
        send_gap_pct <= 29;
        recv_stall_pct <= 47;
      end else if (p < 6) begin
        send_gap_pct <= 47;
        recv_stall_pct <= 29;
      end else begin
        send_gap_pct <= 0;
        recv_stall_pct <= 0;
      end
      program_frame(9'(phase_w[p]), 9'(phase_h[p]), $urandom());
      // Odd phases skip the clear, so reads see pixels left at fixed-stride addresses.
      if (p % 2 == 0) send_cmd(cmd_of(OpClear, 0, 0, 0, 0, 0, 0, 0));
      repeat (ItemsPerPhase) send_cmd(make_cmd());
      // Commands run one at a time, so this read returns only once all earlier work is done.
      send_cmd(cmd_of(OpReadPixel, 0, 0, 0, 0, 0, 0, 0));
      in_valid_i <= 1'b0;
      drain_results();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rfsb_pkg.sv
src/rfsb_ram.sv
src/rect_fill_sprite_blitter_unit.sv
dv/rfsb_checker.sv
dv/tb_rect_fill_sprite_blitter_unit.sv
